// ----- rtl/scc_pkg.sv -----
// Shared types and constants for the second-chance sector cache.
// No dependencies; imported by scc_marks, sector_cache_second_chance and tb_top.
package scc_pkg;

  localparam int unsigned SlotsDef      = 64;
  localparam int unsigned SectorBitsDef = 32;
  localparam int unsigned OutSlotW      = 6;
  localparam int unsigned OutSectorW    = 32;
  localparam int unsigned OpW           = 2;

  typedef enum logic [OpW-1:0] {
    OP_ACCESS = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_DROP   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RORD,
    S_RSEC,
    S_CHK,
    S_PUSH,
    S_FREE,
    S_VORD,
    S_VCHK,
    S_VSEC,
    S_SHRD,
    S_SHWR,
    S_INS,
    S_OUT
  } state_e;

  // Update request for the per-slot mark bank.
  typedef struct packed {
    logic load;      // write valid, accessed (= valid) and dirty
    logic hit;       // set accessed, OR dirty
    logic clr_acc;
    logic clr_dirty;
    logic clr_all;
    logic valid;
    logic dirty;
  } mk_cmd_t;

endpackage

// ----- rtl/scc_marks.sv -----
// Per-slot valid, accessed and dirty flags held in flops, cleared by reset.
// Depends on scc_pkg for the mark update command.
module scc_marks #(
  parameter int unsigned SLOTS  = scc_pkg::SlotsDef,
  parameter int unsigned SLOT_W = $clog2(SLOTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::mk_cmd_t   cmd_i,
  input  logic [SLOT_W-1:0]  widx_i,
  input  logic [SLOT_W-1:0]  ridx_i,
  output logic               valid_o,
  output logic               acc_o,
  output logic               dirty_o
);
  import scc_pkg::*;

  logic [SLOTS-1:0] valid_q, acc_q, dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      acc_q   <= '0;
      dirty_q <= '0;
    end else if (cmd_i.clr_all) begin
      valid_q <= '0;
      acc_q   <= '0;
      dirty_q <= '0;
    end else begin
      if (cmd_i.load) begin
        valid_q[widx_i] <= cmd_i.valid;
        acc_q[widx_i]   <= cmd_i.valid;
        dirty_q[widx_i] <= cmd_i.dirty;
      end
      if (cmd_i.hit) begin
        acc_q[widx_i]   <= 1'b1;
        dirty_q[widx_i] <= dirty_q[widx_i] | cmd_i.dirty;
      end
      if (cmd_i.clr_acc) begin
        acc_q[widx_i] <= 1'b0;
      end
      if (cmd_i.clr_dirty) begin
        dirty_q[widx_i] <= 1'b0;
      end
    end
  end

  assign valid_o = valid_q[ridx_i];
  assign acc_o   = acc_q[ridx_i];
  assign dirty_o = dirty_q[ridx_i];

endmodule

// ----- rtl/sector_cache_second_chance.sv -----
// Second-chance bookkeeping for a fully associative disk-sector cache.
// Per rank scanned: order RAM read, sector RAM read, compare; then the result is loaded out.
// Miss: probe slots for a free one, or run the victim pass over ranks, read the victim, move
// ranks to close the order gap and insert; drop also moves ranks. Flush/drain scan each valid
// slot, push extra beats and may stall. One item in flight, next taken after the last.
// Reset: flags and fill count clear at once; the RAMs need no clearing pass.
module sector_cache_second_chance #(
  parameter int unsigned SLOTS       = scc_pkg::SlotsDef,
  parameter int unsigned SECTOR_BITS = scc_pkg::SectorBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [scc_pkg::OpW-1:0]         opcode_i,
  input  logic [31:0]                     sector_i,
  input  logic                            is_write_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [scc_pkg::OutSlotW-1:0]    slot_o,
  output logic                            hit_o,
  output logic                            fill_needed_o,
  output logic                            write_back_o,
  output logic [scc_pkg::OutSectorW-1:0]  write_back_sector_o,
  output logic                            last_o
);
  import scc_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  // Order RAM: rank -> slot, oldest first. Sector RAM: slot -> sector number.
  logic [SlotW-1:0]       ord_mem [SLOTS];
  logic [SECTOR_BITS-1:0] sec_mem [SLOTS];
  logic [SlotW-1:0]       ord_rd_q;
  logic [SECTOR_BITS-1:0] sec_rd_q;
  logic [SlotW-1:0]       ord_raddr, ord_waddr, ord_wdata;
  logic [SlotW-1:0]       sec_raddr, sec_waddr;
  logic                   ord_we, sec_we;

  state_e state_q, state_d;

  // Item being worked on.
  opcode_e                op_q, op_d;
  logic [SECTOR_BITS-1:0] sec_q, sec_d;
  logic                   wr_q, wr_d;
  // Rank cursor, free-slot probe, current slot, fill count.
  logic [SlotW-1:0]       r_q, r_d;
  logic [SlotW-1:0]       idx_q, idx_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [CntW-1:0]        n_q, n_d;
  // Held result; for flush/drain it trails one beat so the final one can carry last.
  logic [SlotW-1:0]       res_slot_q, res_slot_d;
  logic                   res_hit_q, res_hit_d;
  logic                   res_fill_q, res_fill_d;
  logic                   res_wb_q, res_wb_d;
  logic [SECTOR_BITS-1:0] res_wbs_q, res_wbs_d;
  logic                   res_has_q, res_has_d;

  // Output stage.
  logic                   out_valid_q;
  logic                   out_load, out_last;
  logic [SlotW-1:0]       out_slot_q;
  logic                   out_hit_q, out_fill_q, out_wb_q, out_last_q;
  logic [SECTOR_BITS-1:0] out_wbs_q;

  mk_cmd_t                mk_cmd;
  logic [SlotW-1:0]       mk_widx, mk_ridx;
  logic                   mk_valid, mk_acc, mk_dirty;

  logic accept, out_free, last_rank, shift_done, match, sel;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_rank  = (CntW'(r_q) + CntW'(1)) == n_q;
  assign shift_done = (CntW'(r_q) + CntW'(2)) == n_q;
  assign match      = sec_rd_q == sec_q;
  assign sel        = (op_q == OP_DRAIN) || mk_dirty;

  scc_marks #(
    .SLOTS  (SLOTS),
    .SLOT_W (SlotW)
  ) u_marks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mk_cmd),
    .widx_i  (mk_widx),
    .ridx_i  (mk_ridx),
    .valid_o (mk_valid),
    .acc_o   (mk_acc),
    .dirty_o (mk_dirty)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (n_q == '0) begin
            state_d = (opcode_e'(opcode_i) == OP_ACCESS) ? S_FREE : S_OUT;
          end else begin
            state_d = S_RORD;
          end
        end
      end
      S_RORD: state_d = S_RSEC;
      S_RSEC: state_d = S_CHK;
      S_CHK: begin
        case (op_q)
          OP_ACCESS: begin
            if (match) begin
              state_d = S_OUT;
            end else if (last_rank) begin
              state_d = (n_q != CntW'(SLOTS)) ? S_FREE : S_VORD;
            end else begin
              state_d = S_RORD;
            end
          end
          OP_DROP: begin
            if (match) begin
              state_d = last_rank ? S_OUT : S_SHRD;
            end else begin
              state_d = last_rank ? S_OUT : S_RORD;
            end
          end
          default: begin
            if (sel && res_has_q) begin
              state_d = S_PUSH;
            end else begin
              state_d = last_rank ? S_OUT : S_RORD;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (out_free) begin
          state_d = last_rank ? S_OUT : S_RORD;
        end
      end
      S_FREE: begin
        if (!mk_valid) begin
          state_d = S_OUT;
        end
      end
      S_VORD: state_d = S_VCHK;
      S_VCHK: state_d = mk_acc ? S_VORD : S_VSEC;
      S_VSEC: state_d = last_rank ? S_OUT : S_SHRD;
      S_SHRD: state_d = S_SHWR;
      S_SHWR: begin
        if (shift_done) begin
          state_d = (op_q == OP_DROP) ? S_OUT : S_INS;
        end else begin
          state_d = S_SHRD;
        end
      end
      S_INS: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control, RAM ports and mark updates.
  always_comb begin
    in_ready_o = 1'b0;
    op_d       = op_q;
    sec_d      = sec_q;
    wr_d       = wr_q;
    r_d        = r_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    n_d        = n_q;
    res_slot_d = res_slot_q;
    res_hit_d  = res_hit_q;
    res_fill_d = res_fill_q;
    res_wb_d   = res_wb_q;
    res_wbs_d  = res_wbs_q;
    res_has_d  = res_has_q;
    ord_raddr  = r_q;
    ord_we     = 1'b0;
    ord_waddr  = r_q;
    ord_wdata  = ord_rd_q;
    sec_raddr  = slot_q;
    sec_we     = 1'b0;
    sec_waddr  = slot_q;
    mk_cmd     = '0;
    mk_widx    = slot_q;
    mk_ridx    = slot_q;
    out_load   = 1'b0;
    out_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          op_d       = opcode_e'(opcode_i);
          sec_d      = SECTOR_BITS'(sector_i);
          wr_d       = is_write_i;
          r_d        = '0;
          idx_d      = '0;
          res_slot_d = '0;
          res_hit_d  = 1'b0;
          res_fill_d = 1'b0;
          res_wb_d   = 1'b0;
          res_wbs_d  = '0;
          res_has_d  = 1'b0;
        end
      end
      S_RSEC: begin
        slot_d    = ord_rd_q;
        sec_raddr = ord_rd_q;
      end
      S_CHK: begin
        case (op_q)
          OP_ACCESS: begin
            if (match) begin
              mk_cmd.hit   = 1'b1;
              mk_cmd.dirty = wr_q;
              res_slot_d   = slot_q;
              res_hit_d    = 1'b1;
            end else if (last_rank) begin
              r_d   = '0;
              idx_d = '0;
            end else begin
              r_d = r_q + SlotW'(1);
            end
          end
          OP_DROP: begin
            if (match) begin
              // Invalidate now; the order RAM gap closes in the shift loop.
              mk_cmd.load = 1'b1;
              res_slot_d  = slot_q;
              res_hit_d   = 1'b1;
              if (last_rank) begin
                n_d = n_q - CntW'(1);
              end
            end else if (!last_rank) begin
              r_d = r_q + SlotW'(1);
            end
          end
          default: begin
            if (sel) begin
              mk_cmd.clr_dirty = 1'b1;
            end
            if (sel && !res_has_q) begin
              res_slot_d = slot_q;
              res_wb_d   = 1'b1;
              res_wbs_d  = sec_rd_q;
              res_has_d  = 1'b1;
            end
            if (!(sel && res_has_q)) begin
              if (last_rank) begin
                if (op_q == OP_DRAIN) begin
                  mk_cmd.clr_all = 1'b1;
                  n_d            = '0;
                end
              end else begin
                r_d = r_q + SlotW'(1);
              end
            end
          end
        endcase
      end
      S_PUSH: begin
        // Release the held beat without last, then hold the new one.
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b0;
          res_slot_d = slot_q;
          res_wbs_d  = sec_rd_q;
          if (last_rank) begin
            if (op_q == OP_DRAIN) begin
              mk_cmd.clr_all = 1'b1;
              n_d            = '0;
            end
          end else begin
            r_d = r_q + SlotW'(1);
          end
        end
      end
      S_FREE: begin
        mk_ridx = idx_q;
        mk_widx = idx_q;
        if (!mk_valid) begin
          mk_cmd.load  = 1'b1;
          mk_cmd.valid = 1'b1;
          mk_cmd.dirty = wr_q;
          sec_we       = 1'b1;
          sec_waddr    = idx_q;
          ord_we       = 1'b1;
          ord_waddr    = SlotW'(n_q);
          ord_wdata    = idx_q;
          n_d          = n_q + CntW'(1);
          res_slot_d   = idx_q;
          res_fill_d   = 1'b1;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      S_VCHK: begin
        // Second chance: clear a set mark and move on, wrapping to the oldest.
        mk_ridx = ord_rd_q;
        mk_widx = ord_rd_q;
        if (mk_acc) begin
          mk_cmd.clr_acc = 1'b1;
          r_d            = last_rank ? '0 : r_q + SlotW'(1);
        end else begin
          slot_d    = ord_rd_q;
          sec_raddr = ord_rd_q;
        end
      end
      S_VSEC: begin
        res_slot_d   = slot_q;
        res_fill_d   = 1'b1;
        res_wb_d     = mk_dirty;
        res_wbs_d    = mk_dirty ? sec_rd_q : '0;
        mk_cmd.load  = 1'b1;
        mk_cmd.valid = 1'b1;
        mk_cmd.dirty = wr_q;
        sec_we       = 1'b1;
      end
      S_SHRD: begin
        ord_raddr = r_q + SlotW'(1);
      end
      S_SHWR: begin
        ord_we    = 1'b1;
        ord_waddr = r_q;
        ord_wdata = ord_rd_q;
        r_d       = r_q + SlotW'(1);
        if (shift_done && (op_q == OP_DROP)) begin
          n_d = n_q - CntW'(1);
        end
      end
      S_INS: begin
        // The evicted slot now holds the newest entry.
        ord_we    = 1'b1;
        ord_waddr = SlotW'(n_q - CntW'(1));
        ord_wdata = slot_q;
      end
      S_OUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // RAMs: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sec_we) begin
      sec_mem[sec_waddr] <= sec_q;
    end
    sec_rd_q <= sec_mem[sec_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sec_q      <= sec_d;
    wr_q       <= wr_d;
    r_q        <= r_d;
    idx_q      <= idx_d;
    slot_q     <= slot_d;
    res_slot_q <= res_slot_d;
    res_hit_q  <= res_hit_d;
    res_fill_q <= res_fill_d;
    res_wb_q   <= res_wb_d;
    res_wbs_q  <= res_wbs_d;
    res_has_q  <= res_has_d;
    if (out_load) begin
      out_slot_q <= res_slot_q;
      out_hit_q  <= res_hit_q;
      out_fill_q <= res_fill_q;
      out_wb_q   <= res_wb_q;
      out_wbs_q  <= res_wbs_q;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign slot_o              = OutSlotW'(out_slot_q);
  assign hit_o               = out_hit_q;
  assign fill_needed_o       = out_fill_q;
  assign write_back_o        = out_wb_q;
  assign write_back_sector_o = OutSectorW'(out_wbs_q);
  assign last_o              = out_last_q;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for sector_cache_second_chance: random and directed cache operations,
// with results checked against an in-bench second-chance predictor.
// Depends on scc_pkg and the RTL of sector_cache_second_chance.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCH_LIMIT = 40000;

  typedef struct packed {
    opcode_e     op;
    logic [31:0] sector;
    logic        wr;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        fill;
    logic        wb;
    logic [31:0] wb_sector;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OpW-1:0] opcode_i = '0;
  logic [31:0] sector_i = '0;
  logic is_write_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OutSlotW-1:0] slot_o;
  logic hit_o, fill_needed_o, write_back_o, last_o;
  logic [OutSectorW-1:0] write_back_sector_o;

  sector_cache_second_chance dut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state: its own copy of the cache bookkeeping.
  logic        pv_valid [NSLOT];
  logic [31:0] pv_sector[NSLOT];
  logic        pv_acc   [NSLOT];
  logic        pv_dirty [NSLOT];
  int          pv_rank  [NSLOT];

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   n_errors = 0;
  bit   stim_done = 1'b0;
  bit   long_hold = 1'b0;
  logic [31:0] recent_sectors[$];
  bit   accepted_in = 1'b0;
  int   accepted_in_total = 0;
  int   idle_cycles = 0;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic res_t mk_res(int s, bit h, bit f, bit w, logic [31:0] sec, bit l);
    res_t r;
    r.slot = s[5:0]; r.hit = h; r.fill = f; r.wb = w; r.wb_sector = sec; r.last = l;
    return r;
  endfunction

  // Work out the results of one command and advance the predicted state.
  task automatic predict_cache(input cmd_t c);
    int ord[NSLOT];
    int n, pos, s, v, k;
    logic wbf;
    logic [31:0] wbs;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (pv_valid[i]) begin
        ord[pv_rank[i]] = i;
        n++;
      end
    if (c.op == OP_ACCESS || c.op == OP_DROP) begin
      pos = -1;
      for (int i = 0; i < n; i++)
        if (pos < 0 && pv_sector[ord[i]] == c.sector) pos = i;
      if (c.op == OP_DROP) begin
        if (pos < 0) begin
          expected_results.push_back(mk_res(0, 0, 0, 0, '0, 1));
        end else begin
          s = ord[pos];
          for (int j = pos + 1; j < n; j++) pv_rank[ord[j]] = j - 1;
          pv_valid[s] = 0; pv_acc[s] = 0; pv_dirty[s] = 0;
          expected_results.push_back(mk_res(s, 1, 0, 0, '0, 1));
        end
      end else if (pos >= 0) begin
        s = ord[pos];
        pv_acc[s] = 1;
        pv_dirty[s] = pv_dirty[s] | c.wr;
        expected_results.push_back(mk_res(s, 1, 0, 0, '0, 1));
      end else begin
        s = -1; wbf = 0; wbs = '0;
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && !pv_valid[i]) s = i;
        if (s >= 0) begin
          pv_rank[s] = n;
        end else begin
          // Second chance: clear marks up to the first unmarked entry.
          v = -1;
          for (int i = 0; i < n; i++)
            if (v < 0) begin
              if (!pv_acc[ord[i]]) v = i;
              else pv_acc[ord[i]] = 0;
            end
          if (v < 0) v = 0;
          s = ord[v];
          wbf = pv_dirty[s];
          wbs = wbf ? pv_sector[s] : '0;
          for (int j = v + 1; j < n; j++) pv_rank[ord[j]] = j - 1;
          pv_rank[s] = n - 1;
        end
        pv_valid[s] = 1; pv_sector[s] = c.sector; pv_acc[s] = 1; pv_dirty[s] = c.wr;
        expected_results.push_back(mk_res(s, 0, 1, wbf, wbs, 1));
      end
    end else begin
      k = 0;
      for (int i = 0; i < n; i++) begin
        s = ord[i];
        if (c.op == OP_DRAIN || pv_dirty[s]) begin
          expected_results.push_back(mk_res(s, 0, 0, 1, pv_sector[s], 0));
          k++;
          pv_dirty[s] = 0;
        end
      end
      if (c.op == OP_DRAIN)
        for (int i = 0; i < NSLOT; i++) begin
          pv_valid[i] = 0; pv_acc[i] = 0; pv_dirty[i] = 0;
        end
      if (k == 0) expected_results.push_back(mk_res(0, 0, 0, 0, '0, 1));
      else expected_results[$].last = 1'b1;
    end
  endtask

  function automatic cmd_t mk_cmd(opcode_e op, logic [31:0] sec, logic wr);
    cmd_t c;
    c.op = op; c.sector = sec; c.wr = wr;
    return c;
  endfunction

  // Pick a sector: mostly reuse a small working set so hits and evictions happen.
  function automatic logic [31:0] pick_sector();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'(1000 + $urandom_range(0, 79));
    if (r < 75 && recent_sectors.size() > 0)
      return recent_sectors[$urandom_range(0, recent_sectors.size() - 1)];
    return $urandom();
  endfunction

  initial begin
    logic [31:0] sec;
    int r;
    for (int i = 0; i < NSLOT; i++) begin
      pv_valid[i] = 0; pv_acc[i] = 0; pv_dirty[i] = 0; pv_rank[i] = 0; pv_sector[i] = '0;
    end
    // Directed part: empty flush and drain, field extremes, hits, drops.
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 32'h0, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_DRAIN, 32'hFFFF_FFFF, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_DROP, 32'h0, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'h0, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'hFFFF_FFFF, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'hAAAA_5555, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'h0, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'hFFFF_FFFF, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 32'h1234, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 32'h0, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_DROP, 32'hAAAA_5555, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_DROP, 32'h5555_AAAA, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'h5555_AAAA, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_DRAIN, 32'h0, 1'b0));
    // Fill the cache past capacity so the victim pass runs, all marks set.
    for (int i = 0; i < NSLOT + 4; i++)
      pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'(2000 + i), i[0]));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'd2010, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_ACCESS, 32'd3000, 1'b1));
    pending_cmds.push_back(mk_cmd(OP_FLUSH, 32'h0, 1'b0));
    pending_cmds.push_back(mk_cmd(OP_DRAIN, 32'h0, 1'b0));
    // Random part: mostly accesses over a working set larger than the cache.
    for (int i = 0; i < 110; i++) begin
      r = $urandom_range(0, 99);
      sec = pick_sector();
      if (recent_sectors.size() > 16) void'(recent_sectors.pop_front());
      recent_sectors.push_back(sec);
      if (r < 80) pending_cmds.push_back(mk_cmd(OP_ACCESS, sec, 1'($urandom())));
      else if (r < 90) pending_cmds.push_back(mk_cmd(OP_DROP, sec, 1'($urandom())));
      else if (r < 96) pending_cmds.push_back(mk_cmd(OP_FLUSH, $urandom(), 1'($urandom())));
      else pending_cmds.push_back(mk_cmd(OP_DRAIN, $urandom(), 1'($urandom())));
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // Driver: bursts of beats separated by random gaps; hold payload until accepted.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !accepted_in) begin
        // hold the beat
      end else if (pending_cmds.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        opcode_i   <= pending_cmds[0].op;
        sector_i   <= pending_cmds[0].sector;
        is_write_i <= pending_cmds[0].wr;
        in_valid_i <= 1'b1;
        void'(pending_cmds.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Capture accepted input beats at the rising edge and feed the predictor.
  always @(posedge clk_i) begin
    accepted_in <= in_valid_i && in_ready_o && rst_ni;
    if (rst_ni && in_valid_i && in_ready_o)
      predict_cache(mk_cmd(opcode_e'(opcode_i), sector_i, is_write_i));
  end

  // Receiver stall pattern, with one long hold-off once the cache is busy.
  int rx_phase = 0;
  int hold_cnt = 0;
  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (!long_hold && accepted_in_total == 40) begin
      long_hold <= 1'b1;
      hold_cnt <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if ((rx_phase / 64) % 3 == 2) begin
      out_ready_i <= 1'b1;               // stretch with no stalling
    end else begin
      out_ready_i <= (rx_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      accepted_in_total <= accepted_in_total + 1;
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d", slot_o));
      end else begin
        want = expected_results.pop_front();
        if (slot_o !== want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", slot_o, want.slot));
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit %0b, want %0b", hit_o, want.hit));
        if (fill_needed_o !== want.fill)
          report_mismatch($sformatf("fill_needed %0b, want %0b", fill_needed_o, want.fill));
        if (write_back_o !== want.wb)
          report_mismatch($sformatf("write_back %0b, want %0b", write_back_o, want.wb));
        if (write_back_sector_o !== want.wb_sector)
          report_mismatch($sformatf("write_back_sector %h, want %h",
                                    write_back_sector_o, want.wb_sector));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  // Watchdog and end of run.
  initial begin
    @(posedge rst_ni);
    while (!(stim_done && !in_valid_i && expected_results.size() == 0)) begin
      @(posedge clk_i);
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
    repeat (600) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- sector_cache_second_chance.f -----
rtl/scc_pkg.sv
rtl/scc_marks.sv
rtl/sector_cache_second_chance.sv
verif/tb_top.sv
